### hw/rtl/psfp_pkg.sv
package psfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgLenW  = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned HeadBytes = 3;
  localparam int unsigned MinFrame  = 5;

  localparam logic [ByteW-1:0]   PreFirstRst  = 8'd170;
  localparam logic [ByteW-1:0]   PreSecondRst = 8'd85;
  localparam logic [ByteW-1:0]   IndexRst     = 8'd1;
  localparam logic [CfgLenW-1:0] LengthRst    = 7'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRE_FIRST  = 2'd0,
    CFG_PRE_SECOND = 2'd1,
    CFG_FRAME_IDX  = 2'd2,
    CFG_FRAME_LEN  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic start_frame;
    logic store_data;
    logic store_sum;
    logic emit_start;
    logic emit_rd;
    logic emit_load;
  } dp_cmd_t;

  typedef struct packed {
    logic pre_first_hit;
    logic pre_second_hit;
    logic index_hit;
    logic count_done;
    logic sum_hit;
    logic emit_last;
    logic out_free;
  } dp_sts_t;

endpackage

### hw/rtl/psfp_rx_if.sv
interface psfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/psfp_frame_if.sv
interface psfp_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

### hw/rtl/psfp_ctrl.sv
module psfp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psfp_pkg::dp_sts_t sts_i,
  output psfp_pkg::dp_cmd_t cmd_o
);
  import psfp_pkg::*;

  typedef enum logic [2:0] {
    S_HUNT1,
    S_HUNT2,
    S_INDEX,
    S_DATA,
    S_SUM,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q != S_EMIT_RD) && (state_q != S_EMIT_LD);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_HUNT1: begin
        if (in_fire) state_d = sts_i.pre_first_hit ? S_HUNT2 : S_HUNT1;
      end
      S_HUNT2: begin
        // a failed second sync byte is not retried as a first one
        if (in_fire) state_d = sts_i.pre_second_hit ? S_INDEX : S_HUNT1;
      end
      S_INDEX: begin
        if (in_fire) begin
          cmd_o.start_frame = sts_i.index_hit;
          state_d = sts_i.index_hit ? S_DATA : S_HUNT1;
        end
      end
      S_DATA: begin
        if (in_fire) begin
          cmd_o.store_data = 1'b1;
          state_d = sts_i.count_done ? S_SUM : S_DATA;
        end
      end
      S_SUM: begin
        if (in_fire) begin
          cmd_o.store_sum  = 1'b1;
          cmd_o.emit_start = sts_i.sum_hit;
          state_d = sts_i.sum_hit ? S_EMIT_RD : S_HUNT1;
        end
      end
      S_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        // hold until the output register has room
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d = sts_i.emit_last ? S_HUNT1 : S_EMIT_RD;
        end
      end
      default: state_d = S_HUNT1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT1;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/psfp_dp.sv
module psfp_dp #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [psfp_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [psfp_pkg::ByteW-1:0]    rx_byte_i,
  input  psfp_pkg::dp_cmd_t             cmd_i,
  output psfp_pkg::dp_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [psfp_pkg::ByteW-1:0]    out_byte_o,
  output logic                          out_last_o
);
  import psfp_pkg::*;

  localparam int unsigned MemDepth = MAX_FRAME - HeadBytes;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned LenW     = $clog2(MAX_FRAME + 1);
  localparam int unsigned CmpW     = (LenW > CfgLenW) ? LenW : CfgLenW;

  logic [ByteW-1:0]   pre_first_q, pre_second_q, frame_idx_q;
  logic [CfgLenW-1:0] frame_len_q;

  logic [ByteW-1:0] lat_pre1_q, lat_pre2_q, lat_index_q;
  logic [LenW-1:0]  lat_len_q, len_clamped;
  logic [CmpW-1:0]  len_ext;

  logic [LenW-1:0]  byte_count_q, emit_idx_q;
  logic [ByteW-1:0] running_sum_q;

  logic [ByteW-1:0] mem_q [MemDepth];
  logic [ByteW-1:0] rdata_q;
  logic [AddrW-1:0] wr_addr, rd_addr;

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q, head_byte;
  logic             out_last_q;
  logic [LenW:0]    count_next2;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_first_q  <= PreFirstRst;
      pre_second_q <= PreSecondRst;
      frame_idx_q  <= IndexRst;
      frame_len_q  <= LengthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_PRE_FIRST:  pre_first_q  <= cfg_wdata_i[ByteW-1:0];
        CFG_PRE_SECOND: pre_second_q <= cfg_wdata_i[ByteW-1:0];
        CFG_FRAME_IDX:  frame_idx_q  <= cfg_wdata_i[ByteW-1:0];
        CFG_FRAME_LEN:  frame_len_q  <= cfg_wdata_i[CfgLenW-1:0];
        default: ;
      endcase
    end
  end

  assign len_ext = CmpW'(frame_len_q);

  always_comb begin
    priority if (len_ext < CmpW'(MinFrame)) begin
      len_clamped = LenW'(MinFrame);
    end else if (len_ext > CmpW'(MAX_FRAME)) begin
      len_clamped = LenW'(MAX_FRAME);
    end else begin
      len_clamped = LenW'(len_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_frame) begin
      lat_len_q   <= len_clamped;
      lat_pre1_q  <= pre_first_q;
      lat_pre2_q  <= pre_second_q;
      lat_index_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q  <= '0;
      running_sum_q <= '0;
      emit_idx_q    <= '0;
    end else begin
      if (cmd_i.start_frame) begin
        byte_count_q  <= LenW'(HeadBytes);
        running_sum_q <= rx_byte_i;
      end else if (cmd_i.store_data) begin
        byte_count_q  <= byte_count_q + LenW'(1);
        running_sum_q <= running_sum_q + rx_byte_i;
      end
      if (cmd_i.emit_start) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_load) begin
        emit_idx_q <= emit_idx_q + LenW'(1);
      end
    end
  end

  // payload and checksum share one store, slot = byte count minus header
  assign wr_addr = AddrW'(byte_count_q - LenW'(HeadBytes));
  assign rd_addr = (emit_idx_q >= LenW'(HeadBytes)) ?
                   AddrW'(emit_idx_q - LenW'(HeadBytes)) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_data || cmd_i.store_sum) begin
      mem_q[wr_addr] <= rx_byte_i;
    end
    if (cmd_i.emit_rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    priority if (emit_idx_q == LenW'(0)) begin
      head_byte = lat_pre1_q;
    end else if (emit_idx_q == LenW'(1)) begin
      head_byte = lat_pre2_q;
    end else if (emit_idx_q == LenW'(2)) begin
      head_byte = lat_index_q;
    end else begin
      head_byte = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_byte_q <= head_byte;
      out_last_q <= sts_o.emit_last;
    end
  end

  assign count_next2 = {1'b0, byte_count_q} + (LenW+1)'(2);

  assign sts_o.pre_first_hit  = (rx_byte_i == pre_first_q);
  assign sts_o.pre_second_hit = (rx_byte_i == pre_second_q);
  assign sts_o.index_hit      = (rx_byte_i == frame_idx_q);
  assign sts_o.count_done     = (count_next2 >= {1'b0, lat_len_q});
  assign sts_o.sum_hit        = (rx_byte_i == running_sum_q);
  assign sts_o.emit_last      = (emit_idx_q == lat_len_q - LenW'(1));
  assign sts_o.out_free       = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

### hw/rtl/preamble_sum_frame_parser.sv
// Serial frame parser. While hunting and collecting a frame it takes one rx
// beat per clock. Once the checksum beat of a good frame arrives, rx is held
// off while the frame is replayed (header from latched registers, payload
// and checksum from the payload memory). Each output beat is a memory read,
// then an output register load, plus any output stall; no rx beat is taken
// until the last beat is loaded. That beat sits in the output register
// while the parser already hunts again. Frames with a wrong index or bad
// checksum vanish without output. No clearing pass after reset is needed.
module preamble_sum_frame_parser #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [psfp_pkg::CfgDataW-1:0] cfg_wdata_i,
  psfp_rx_if.sink                       rx_i,
  psfp_frame_if.source                  frame_o
);
  import psfp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  psfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psfp_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (rx_i.rx_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (frame_o.valid),
    .out_ready_i (frame_o.ready),
    .out_byte_o  (frame_o.frame_byte),
    .out_last_o  (frame_o.frame_last)
  );

  // never overwrite a beat that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_load |-> (!frame_o.valid || frame_o.ready))
    else $error("output beat overwritten");

  // memory writes only happen on an accepted rx beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.store_data || cmd.store_sum) |-> (rx_i.valid && rx_i.ready))
    else $error("store without rx beat");

  // after the final beat is loaded, rx opens again at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_load && sts.emit_last) |=> (rx_i.ready && frame_o.valid && frame_o.frame_last))
    else $error("rx not reopened after frame replay");

  // replay runs with rx closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_rd |-> !rx_i.ready)
    else $error("rx open during replay");

endmodule
